// ----- rtl/core/lfr_pkg.sv -----
// ----------------------------------------------------------------------------
// LCD framebuffer refresh package
// Shared sizes, protocol constants, function codes and the framebuffer
// request structure.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int DISPLAY_ROWS = 64;
    localparam int DISPLAY_COLS = 128;
    localparam int ROW_BYTES    = (DISPLAY_COLS + 7) / 8;
    localparam int STORE_DEPTH  = 1024;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int ROW_W        = $clog2(DISPLAY_ROWS);
    localparam int COL_W        = $clog2(DISPLAY_COLS);
    localparam int BCOL_W       = 5;

    localparam logic [7:0] SYNC_BYTE       = 8'hF8;
    localparam logic [7:0] NIBBLE_MASK     = 8'hF0;
    localparam logic [7:0] ADDR_BASE       = 8'h80;
    localparam logic [7:0] LOWER_HALF_BASE = 8'h88;
    localparam logic [7:0] PIXEL_MSB       = 8'h80;
    localparam logic [7:0] HALF_ROW        = 8'd32;

    localparam logic [6:0] RECT_TOP_RST    = 7'd64;
    localparam logic [6:0] RECT_BOTTOM_RST = 7'd0;
    localparam logic [7:0] RECT_LEFT_RST   = 8'd128;
    localparam logic [7:0] RECT_RIGHT_RST  = 8'd0;

    localparam logic [1:0] FUNC_SET     = 2'd0;
    localparam logic [1:0] FUNC_REFRESH = 2'd1;
    localparam logic [1:0] FUNC_RAW     = 2'd2;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic       en;
        logic       we;
        t_addr      addr;
        logic [7:0] wdata;
    } t_fb_req;

endpackage

// ----- rtl/core/lfr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/lfr_fbuf.sv -----
// ----------------------------------------------------------------------------
// Framebuffer store
// Byte-wide pixel memory with a clearing sweep that zeroes every entry
// after reset before requests are served.
// ----------------------------------------------------------------------------
module lfr_fbuf import lfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fb_req    i_req,
    output logic [7:0] o_rdata,
    output logic       o_ready
);

    logic    r_clearing;
    t_addr   r_clr_addr;
    logic    n_clearing;
    t_addr   n_clr_addr;
    t_fb_req ram_req;

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + t_addr'(1);
            if (r_clr_addr == t_addr'(STORE_DEPTH - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_comb begin
        if (r_clearing) begin
            ram_req.en    = 1'b1;
            ram_req.we    = 1'b1;
            ram_req.addr  = r_clr_addr;
            ram_req.wdata = '0;
        end else begin
            ram_req = i_req;
        end
    end

    lfr_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_en   (ram_req.en),
        .i_we   (ram_req.we),
        .i_addr (ram_req.addr),
        .i_wdata(ram_req.wdata),
        .o_rdata(o_rdata)
    );

    assign o_ready = ~r_clearing;

endmodule

// ----- rtl/core/lcd_framebuffer_serial_refresh.sv -----
// ----------------------------------------------------------------------------
// LCD framebuffer serial refresh
// Set-pixel read-modify-write into a byte framebuffer with a dirty
// rectangle, and serial byte generation for refresh and raw transfers.
// ----------------------------------------------------------------------------
// Set pixel: busy for the memory read, then the write; the ack follows in the cycle after the write.
// Refresh: 12 words, one per cycle, generated in the send state; busy while generating.
// Raw: 3 words, one per cycle, generated in the send state; busy while generating.
// Unused code or refresh row off the panel: no words, and the block does not go busy.
// After reset a clearing pass zeroes the 1024-entry store; busy until it completes.
// Results cannot be stalled; each word is shown for exactly one cycle.
module lcd_framebuffer_serial_refresh import lfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic [7:0] i_pixel_col,
    input  logic [7:0] i_pixel_row,
    input  logic [2:0] i_word_col,
    input  logic       i_is_data,
    input  logic [7:0] i_raw_byte,
    output logic       o_strobe,
    output logic       o_is_ack,
    output logic [7:0] o_serial_byte,
    output logic       o_last,
    output logic [6:0] o_dirty_top,
    output logic [6:0] o_dirty_bottom,
    output logic [7:0] o_dirty_left,
    output logic [7:0] o_dirty_right
);

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RD   = 5'b00100,
        S_WR   = 5'b01000,
        S_SEND = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_txn, n_txn;
    logic [1:0]       r_ph, n_ph;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_inrange;
    logic [2:0]       r_wc;
    logic             r_raw;
    logic             r_rs;
    logic [7:0]       r_raw_byte;
    logic [7:0]       r_data0, r_data1;
    logic [6:0]       r_top, r_bottom, n_top, n_bottom;
    logic [7:0]       r_left, r_right, n_left, n_right;
    logic             r_strobe, n_strobe;
    logic             r_is_ack, n_is_ack;
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;

    logic             accept;
    logic             row_ok, col_ok;
    t_fb_req          fb_req;
    logic [7:0]       fb_rdata;
    logic             fb_ready;
    t_addr            pix_addr, row_base;
    logic [BCOL_W-1:0] bcol0, bcol1;
    logic             bc0_ok, bc1_ok;
    logic [7:0]       row_cmd, col_cmd, payload;
    logic             rs;
    logic [7:0]       mask;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign row_ok = (i_pixel_row < 8'(DISPLAY_ROWS));
    assign col_ok = (i_pixel_col < 8'(DISPLAY_COLS));

    assign row_base = t_addr'(r_row) * t_addr'(ROW_BYTES);
    assign pix_addr = row_base + t_addr'(r_col[COL_W-1:3]);
    assign bcol0    = BCOL_W'({r_wc, 1'b0});
    assign bcol1    = BCOL_W'({r_wc, 1'b1});
    assign bc0_ok   = (bcol0 < BCOL_W'(ROW_BYTES));
    assign bc1_ok   = (bcol1 < BCOL_W'(ROW_BYTES));
    assign mask     = PIXEL_MSB >> r_col[2:0];

    assign row_cmd = ADDR_BASE | {3'b000, r_row[4:0]};
    assign col_cmd = ((8'(r_row) >= HALF_ROW) ? LOWER_HALF_BASE : ADDR_BASE)
                     | {5'b00000, r_wc};

    always_comb begin
        case (r_txn)
            2'd0:    payload = row_cmd;
            2'd1:    payload = col_cmd;
            2'd2:    payload = r_data0;
            default: payload = r_raw ? r_raw_byte : r_data1;
        endcase
        rs = r_raw ? r_rs : r_txn[1];
    end

    always_comb begin
        fb_req.en    = 1'b0;
        fb_req.we    = 1'b0;
        fb_req.addr  = pix_addr;
        fb_req.wdata = fb_rdata | mask;
        case (r_state)
            S_RD: begin
                fb_req.en = 1'b1;
            end
            S_WR: begin
                fb_req.en = r_inrange;
                fb_req.we = 1'b1;
            end
            S_SEND: begin
                if (r_txn == 2'd0 && r_ph == 2'd0) begin
                    fb_req.en   = 1'b1;
                    fb_req.addr = row_base + t_addr'(bcol0);
                end else if (r_txn == 2'd0 && r_ph == 2'd1) begin
                    fb_req.en   = 1'b1;
                    fb_req.addr = row_base + t_addr'(bcol1);
                end
            end
            default: begin
            end
        endcase
    end

    lfr_fbuf u_fbuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (fb_req),
        .o_rdata(fb_rdata),
        .o_ready(fb_ready)
    );

    always_comb begin
        n_state  = r_state;
        n_txn    = r_txn;
        n_ph     = r_ph;
        n_top    = r_top;
        n_bottom = r_bottom;
        n_left   = r_left;
        n_right  = r_right;
        n_strobe = 1'b0;
        n_is_ack = 1'b0;
        n_byte   = '0;
        n_last   = 1'b0;
        case (r_state)
            S_CLR: begin
                if (fb_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_ph = 2'd0;
                    case (i_func)
                        FUNC_SET: begin
                            n_state = S_RD;
                        end
                        FUNC_REFRESH: begin
                            if (row_ok) begin
                                n_state = S_SEND;
                                n_txn   = 2'd0;
                            end
                        end
                        FUNC_RAW: begin
                            n_state = S_SEND;
                            n_txn   = 2'd3;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_is_ack = 1'b1;
                n_last   = 1'b1;
                if (r_inrange) begin
                    if (r_top > 7'(r_row)) begin
                        n_top = 7'(r_row);
                    end
                    if (r_bottom <= 7'(r_row)) begin
                        n_bottom = 7'(r_row) + 7'd1;
                    end
                    if (r_left > 8'(r_col)) begin
                        n_left = 8'(r_col);
                    end
                    if (r_right <= 8'(r_col)) begin
                        n_right = 8'(r_col) + 8'd1;
                    end
                end
            end
            S_SEND: begin
                n_strobe = 1'b1;
                case (r_ph)
                    2'd0:    n_byte = SYNC_BYTE | {6'b000000, rs, 1'b0};
                    2'd1:    n_byte = payload & NIBBLE_MASK;
                    default: n_byte = {payload[3:0], 4'b0000};
                endcase
                if (r_ph == 2'd2) begin
                    n_ph  = 2'd0;
                    n_txn = r_txn + 2'd1;
                    if (r_txn == 2'd3) begin
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_txn    <= '0;
            r_ph     <= '0;
            r_top    <= RECT_TOP_RST;
            r_bottom <= RECT_BOTTOM_RST;
            r_left   <= RECT_LEFT_RST;
            r_right  <= RECT_RIGHT_RST;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_txn    <= n_txn;
            r_ph     <= n_ph;
            r_top    <= n_top;
            r_bottom <= n_bottom;
            r_left   <= n_left;
            r_right  <= n_right;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_ack <= n_is_ack;
        r_byte   <= n_byte;
        r_last   <= n_last;
        if (accept) begin
            r_row      <= i_pixel_row[ROW_W-1:0];
            r_col      <= i_pixel_col[COL_W-1:0];
            r_inrange  <= row_ok && col_ok;
            r_wc       <= i_word_col;
            r_raw      <= (i_func == FUNC_RAW);
            r_rs       <= i_is_data;
            r_raw_byte <= i_raw_byte;
        end
        if (r_state == S_SEND && r_txn == 2'd0 && r_ph == 2'd1) begin
            r_data0 <= bc0_ok ? fb_rdata : 8'h00;
        end
        if (r_state == S_SEND && r_txn == 2'd0 && r_ph == 2'd2) begin
            r_data1 <= bc1_ok ? fb_rdata : 8'h00;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_is_ack       = r_is_ack;
    assign o_serial_byte  = r_byte;
    assign o_last         = r_last;
    assign o_dirty_top    = r_top;
    assign o_dirty_bottom = r_bottom;
    assign o_dirty_left   = r_left;
    assign o_dirty_right  = r_right;

endmodule

// ----- rtl/core/lfr_checker.sv -----
// ----------------------------------------------------------------------------
// LCD framebuffer refresh port checker
// Checks word framing and dirty rectangle behavior at the top-level ports.
// ----------------------------------------------------------------------------
module lfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_strobe,
    input logic       o_is_ack,
    input logic [7:0] o_serial_byte,
    input logic       o_last,
    input logic [6:0] o_dirty_top,
    input logic [6:0] o_dirty_bottom,
    input logic [7:0] o_dirty_left,
    input logic [7:0] o_dirty_right
);

    // An acknowledge is always a single, final word with a zero byte.
    a_ack_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_is_ack |-> o_last && (o_serial_byte == 8'h00))
        else $error("acknowledge word malformed");

    // The final serial word closes a three-word transaction.
    a_txn_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_is_ack && o_last |-> $past(o_strobe) && $past(o_strobe, 2))
        else $error("serial transaction shorter than three words");

    // A non-empty dirty rectangle has positive extent in both directions.
    a_rect_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dirty_top != 7'd64) |->
            (o_dirty_top < o_dirty_bottom) && (o_dirty_left < o_dirty_right))
        else $error("dirty rectangle inconsistent");

    // The rectangle, checked by its left edge, only changes while an item is being processed.
    a_rect_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_dirty_left) |-> $past(busy))
        else $error("dirty rectangle changed while idle");

endmodule

bind lcd_framebuffer_serial_refresh lfr_checker u_lfr_checker (.*);
